// ===== hw/rtl/tshd_pkg.sv =====
// Shared constants for the touch sensor hysteresis detector.
`default_nettype none

package tshd_pkg;

  localparam int FracBits = 8;
  localparam int CntW     = 10;
  localparam int LvlW     = 7;
  localparam int GainW    = 12;
  localparam int MaskW    = 8;
  localparam int ChW      = 3;
  localparam int ChgW     = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] RegAvgCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTouchLvl = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRelLvl   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGain     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegToggle   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIgnore   = 3'd5;

  localparam logic [CntW-1:0]  AvgCountRst = 10'd200;
  localparam logic [LvlW-1:0]  TouchLvlRst = 7'd95;
  localparam logic [LvlW-1:0]  RelLvlRst   = 7'd65;
  localparam logic [GainW-1:0] GainRst     = 12'd256;

  localparam logic [LvlW-1:0]  PctMax      = 7'd100;
  localparam logic [LvlW-1:0]  TouchLvlMin = 7'd1;

  localparam logic [ChgW-1:0] ChgNone    = 2'd0;
  localparam logic [ChgW-1:0] ChgTouch   = 2'd1;
  localparam logic [ChgW-1:0] ChgRelease = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/tshd_if.sv =====
// Handshake channel interfaces for samples, results and register writes.
`default_nettype none

interface tshd_in_if #(
  parameter int SampleBits = 10
);
  logic                          valid;
  logic                          ready;
  logic [tshd_pkg::ChW-1:0]      channel;
  logic [SampleBits-1:0]         sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface tshd_out_if;
  logic                          valid;
  logic                          ready;
  logic [tshd_pkg::ChW-1:0]      out_channel;
  logic [tshd_pkg::LvlW-1:0]     percent;
  logic                          touched;
  logic [tshd_pkg::ChgW-1:0]     change;

  modport source (output valid, output out_channel, output percent, output touched,
                  output change, input ready);
  modport sink   (input valid, input out_channel, input percent, input touched,
                  input change, output ready);
endinterface

interface tshd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tshd_pkg::CfgIdxW-1:0]  index;
  logic [tshd_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/touch_sensor_hysteresis_detector.sv =====
// Top level of the touch sensor hysteresis detector.
// Each accepted item (channel, sample) yields one result item with the scaled proximity
// percent, the reported touch status and a change code. The block handles one item at a
// time: with the filter on, an item passes the average multiply and the restoring divider
// that retires one quotient bit per cycle over SAMPLE_BITS + 8 steps, then the average
// write, gain, percent and clamp steps; with the filter bypassed it starts at the gain
// step, and on an ignored channel it goes straight to the output. One multiplier is reused
// for the average update and the two scaling products. A finished result waits in the
// output register while the next item is accepted. Register writes are taken in any cycle.
`default_nettype none

module touch_sensor_hysteresis_detector #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tshd_in_if.sink         in_if,
  tshd_out_if.source      out_if,
  tshd_cfg_if.sink        cfg_if
);

  localparam int AW     = SAMPLE_BITS + tshd_pkg::FracBits;
  localparam int DW     = AW + tshd_pkg::CntW;
  localparam int MA     = SAMPLE_BITS + tshd_pkg::GainW;
  localparam int MB     = tshd_pkg::GainW;
  localparam int PW     = MA + MB;
  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW     = $clog2(AW + 1);
  localparam int LastCh = (CHANNELS > 8) ? 7 : CHANNELS - 1;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StMulAvg = 4'd1;
  localparam logic [3:0] StLoad   = 4'd2;
  localparam logic [3:0] StDiv    = 4'd3;
  localparam logic [3:0] StWrite  = 4'd4;
  localparam logic [3:0] StGain   = 4'd5;
  localparam logic [3:0] StHund   = 4'd6;
  localparam logic [3:0] StPct    = 4'd7;
  localparam logic [3:0] StDone   = 4'd8;

  // configuration
  logic [tshd_pkg::CntW-1:0]  avg_cnt_q;
  logic [tshd_pkg::LvlW-1:0]  touch_lvl_q;
  logic [tshd_pkg::LvlW-1:0]  rel_lvl_q;
  logic [tshd_pkg::GainW-1:0] gain_q;
  logic                       toggle_q;
  logic [tshd_pkg::MaskW-1:0] ignore_q;

  // sequencer and datapath
  logic [3:0]                 state_q, state_d;
  logic [tshd_pkg::ChW-1:0]   ch_q;
  logic [CW-1:0]              idx_q;
  logic [SAMPLE_BITS-1:0]     smp_q;
  logic [SAMPLE_BITS-1:0]     level_q;
  logic [AW-1:0]              avg_rd_q;
  logic [PW-1:0]              prod_q;
  logic [tshd_pkg::CntW-1:0]  rem_q;
  logic [AW-1:0]              quo_q;
  logic [SW-1:0]              step_q;
  logic [tshd_pkg::LvlW-1:0]  pct_q;

  // per-channel state
  logic [AW-1:0]              avg_mem [CHANNELS];
  logic [CHANNELS-1:0]        avg_vld_q;
  logic [CHANNELS-1:0]        act_q;
  logic [CHANNELS-1:0]        psd_q;

  // output register
  logic                       out_valid_q;
  logic [tshd_pkg::ChW-1:0]   out_ch_q;
  logic [tshd_pkg::LvlW-1:0]  out_pct_q;
  logic                       out_touched_q;
  logic [tshd_pkg::ChgW-1:0]  out_chg_q;

  logic                       in_fire;
  logic                       out_load;
  logic [tshd_pkg::ChW-1:0]   ch_in;
  logic [CW-1:0]              idx_in;
  logic                       ignored_in;

  logic [MA-1:0]              mul_a;
  logic [MB-1:0]              mul_b;
  logic [PW-1:0]              mul_p;

  logic [DW-1:0]              dividend;
  logic [tshd_pkg::CntW:0]    trial;
  logic                       trial_ge;
  logic [PW-AW-1:0]           pct_raw;

  logic [tshd_pkg::LvlW-1:0]  t_lvl;
  logic [tshd_pkg::LvlW-1:0]  t_lvl_m1;
  logic [tshd_pkg::LvlW-1:0]  r_lvl;
  logic                       act_cur;
  logic                       psd_cur;
  logic                       status;
  logic                       psd_new;
  logic                       touched_new;
  logic [tshd_pkg::ChgW-1:0]  chg_raw;
  logic [tshd_pkg::ChgW-1:0]  chg_new;

  assign in_if.ready  = (state_q == StIdle);
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign ch_in      = (int'(in_if.channel) > LastCh) ? tshd_pkg::ChW'(LastCh) : in_if.channel;
  assign idx_in     = CW'(ch_in);
  assign ignored_in = ignore_q[ch_in];

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMulAvg: begin
        mul_a = MA'(avg_vld_q[idx_q] ? avg_rd_q : '0);
        mul_b = MB'(avg_cnt_q - tshd_pkg::CntW'(1));
      end
      StGain: begin
        mul_a = MA'(level_q);
        mul_b = gain_q;
      end
      StHund: begin
        mul_a = prod_q[MA-1:0];
        mul_b = MB'(tshd_pkg::PctMax);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // restoring divider step
  assign dividend = prod_q[DW-1:0] + DW'({smp_q, {tshd_pkg::FracBits{1'b0}}});
  assign trial    = {rem_q, quo_q[AW-1]};
  assign trial_ge = (trial >= {1'b0, avg_cnt_q});
  assign pct_raw  = prod_q[PW-1:AW];

  // threshold decision
  always_comb begin
    t_lvl = touch_lvl_q;
    if (touch_lvl_q < tshd_pkg::TouchLvlMin) begin
      t_lvl = tshd_pkg::TouchLvlMin;
    end else if (touch_lvl_q > tshd_pkg::PctMax) begin
      t_lvl = tshd_pkg::PctMax;
    end
    t_lvl_m1 = t_lvl - tshd_pkg::LvlW'(1);
    r_lvl    = (rel_lvl_q < t_lvl_m1) ? rel_lvl_q : t_lvl_m1;

    act_cur = act_q[idx_q];
    psd_cur = psd_q[idx_q];
    chg_raw = tshd_pkg::ChgNone;
    status  = act_cur;
    if (pct_q >= t_lvl) begin
      status  = 1'b1;
      chg_raw = act_cur ? tshd_pkg::ChgNone : tshd_pkg::ChgTouch;
    end else if (pct_q < r_lvl) begin
      status  = 1'b0;
      chg_raw = act_cur ? tshd_pkg::ChgRelease : tshd_pkg::ChgNone;
    end

    psd_new     = psd_cur;
    chg_new     = chg_raw;
    touched_new = status;
    if (toggle_q) begin
      if (chg_raw == tshd_pkg::ChgRelease) begin
        chg_new = tshd_pkg::ChgNone;
      end else if (chg_raw == tshd_pkg::ChgTouch) begin
        psd_new = !psd_cur;
        chg_new = psd_new ? tshd_pkg::ChgTouch : tshd_pkg::ChgRelease;
      end
      touched_new = psd_new;
    end
  end

  assign out_load = (state_q == StDone) && (!out_valid_q || out_if.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (ignored_in) begin
            state_d = StDone;
          end else if (avg_cnt_q == '0) begin
            state_d = StGain;
          end else begin
            state_d = StMulAvg;
          end
        end
      end
      StMulAvg: state_d = StLoad;
      StLoad:   state_d = StDiv;
      StDiv: begin
        if (step_q == SW'(AW - 1)) begin
          state_d = StWrite;
        end
      end
      StWrite:  state_d = StGain;
      StGain:   state_d = StHund;
      StHund:   state_d = StPct;
      StPct:    state_d = StDone;
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_cnt_q   <= tshd_pkg::AvgCountRst;
      touch_lvl_q <= tshd_pkg::TouchLvlRst;
      rel_lvl_q   <= tshd_pkg::RelLvlRst;
      gain_q      <= tshd_pkg::GainRst;
      toggle_q    <= 1'b0;
      ignore_q    <= '0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        tshd_pkg::RegAvgCount: avg_cnt_q   <= cfg_if.data[tshd_pkg::CntW-1:0];
        tshd_pkg::RegTouchLvl: touch_lvl_q <= cfg_if.data[tshd_pkg::LvlW-1:0];
        tshd_pkg::RegRelLvl:   rel_lvl_q   <= cfg_if.data[tshd_pkg::LvlW-1:0];
        tshd_pkg::RegGain:     gain_q      <= cfg_if.data[tshd_pkg::GainW-1:0];
        tshd_pkg::RegToggle:   toggle_q    <= cfg_if.data[0];
        tshd_pkg::RegIgnore:   ignore_q    <= cfg_if.data[tshd_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  // average memory
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      avg_rd_q <= avg_mem[idx_in];
    end
    if (state_q == StWrite) begin
      avg_mem[idx_q] <= quo_q;
    end
  end

  // per-channel flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_vld_q <= '0;
      act_q     <= '0;
      psd_q     <= '0;
    end else begin
      if (state_q == StWrite) begin
        avg_vld_q[idx_q] <= 1'b1;
      end
      if (out_load) begin
        act_q[idx_q] <= status;
        psd_q[idx_q] <= psd_new;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          ch_q    <= ch_in;
          idx_q   <= idx_in;
          smp_q   <= in_if.sample;
          level_q <= in_if.sample;
          pct_q   <= '0;
        end
      end
      StMulAvg: prod_q <= mul_p;
      StLoad: begin
        rem_q  <= dividend[DW-1:AW];
        quo_q  <= dividend[AW-1:0];
        step_q <= '0;
      end
      StDiv: begin
        rem_q  <= trial_ge ? tshd_pkg::CntW'(trial - {1'b0, avg_cnt_q})
                           : trial[tshd_pkg::CntW-1:0];
        quo_q  <= {quo_q[AW-2:0], trial_ge};
        step_q <= step_q + SW'(1);
      end
      StWrite:  level_q <= quo_q[AW-1:tshd_pkg::FracBits];
      StGain:   prod_q  <= mul_p;
      StHund:   prod_q  <= mul_p;
      StPct: begin
        pct_q <= (pct_raw > (PW-AW)'(tshd_pkg::PctMax)) ? tshd_pkg::PctMax
                                                        : pct_raw[tshd_pkg::LvlW-1:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q      <= ch_q;
      out_pct_q     <= pct_q;
      out_touched_q <= touched_new;
      out_chg_q     <= chg_new;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.out_channel = out_ch_q;
  assign out_if.percent     = out_pct_q;
  assign out_if.touched     = out_touched_q;
  assign out_if.change      = out_chg_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_if.ready)
    else $error("input ready while an item is in progress");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pct_q <= tshd_pkg::PctMax)
    else $error("percent above full scale");

  a_chg_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_chg_q == tshd_pkg::ChgNone)
                  || (out_chg_q == tshd_pkg::ChgTouch && out_touched_q)
                  || (out_chg_q == tshd_pkg::ChgRelease && !out_touched_q)))
    else $error("change code disagrees with status");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (step_q < SW'(AW)))
    else $error("divider step count overrun");

endmodule

`default_nettype wire

// ===== test/touch_sensor_hysteresis_detector_test.sv =====
// Self-checking testbench for the touch sensor hysteresis detector.
`timescale 1ns / 1ps

module touch_sensor_hysteresis_detector_test;

  localparam int Channels   = 8;
  localparam int SampleBits = 10;
  localparam int AvgBits    = SampleBits + tshd_pkg::FracBits;
  localparam int HoldCycles = 400;
  localparam int IdleLimit  = 3000;
  localparam int PhaseItems = 119;
  localparam int RandPhases = 8;

  localparam logic [tshd_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [tshd_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [tshd_pkg::ChW-1:0]  ch;
    logic [tshd_pkg::LvlW-1:0] pct;
    logic                      touched;
    logic [tshd_pkg::ChgW-1:0] chg;
  } touch_result_t;

  class touch_scoreboard;
    logic [tshd_pkg::CntW-1:0]  avg_count;
    logic [tshd_pkg::LvlW-1:0]  touch_lvl;
    logic [tshd_pkg::LvlW-1:0]  rel_lvl;
    logic [tshd_pkg::GainW-1:0] gain_q;
    logic                       toggle_on;
    logic [tshd_pkg::MaskW-1:0] ignore_bits;
    logic [AvgBits-1:0]         avg_q[Channels];
    logic                       actual_q[Channels];
    logic                       pseudo_q[Channels];
    touch_result_t              expected_q[$];
    int                         errors;
    int                         n_items;
    int                         n_checked;
    int                         n_touches;
    int                         n_releases;
    int                         n_full;

    function void clear();
      avg_count   = tshd_pkg::AvgCountRst;
      touch_lvl   = tshd_pkg::TouchLvlRst;
      rel_lvl     = tshd_pkg::RelLvlRst;
      gain_q      = tshd_pkg::GainRst;
      toggle_on   = 1'b0;
      ignore_bits = '0;
      for (int c = 0; c < Channels; c++) begin
        avg_q[c]    = '0;
        actual_q[c] = 1'b0;
        pseudo_q[c] = 1'b0;
      end
      expected_q.delete();
    endfunction

    function void write_reg(logic [tshd_pkg::CfgIdxW-1:0] idx,
                            logic [tshd_pkg::CfgDataW-1:0] data);
      case (idx)
        tshd_pkg::RegAvgCount: avg_count   = data[tshd_pkg::CntW-1:0];
        tshd_pkg::RegTouchLvl: touch_lvl   = data[tshd_pkg::LvlW-1:0];
        tshd_pkg::RegRelLvl:   rel_lvl     = data[tshd_pkg::LvlW-1:0];
        tshd_pkg::RegGain:     gain_q      = data[tshd_pkg::GainW-1:0];
        tshd_pkg::RegToggle:   toggle_on   = data[0];
        tshd_pkg::RegIgnore:   ignore_bits = data[tshd_pkg::MaskW-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [tshd_pkg::ChW-1:0] ch, logic [SampleBits-1:0] smp);
      longint unsigned avg_old;
      longint unsigned n;
      longint unsigned acc;
      longint unsigned prod;
      logic [AvgBits-1:0] avg_new;
      logic [SampleBits-1:0] level;
      int t_lvl;
      int r_lvl;
      logic status;
      logic [tshd_pkg::ChgW-1:0] chg;
      touch_result_t r;
      r.ch = ch;
      if (ignore_bits[ch]) begin
        r.pct = '0;
      end else begin
        level = smp;
        if (avg_count != 0) begin
          avg_old = 64'(avg_q[ch]);
          n = 64'(avg_count);
          acc = avg_old * (n - 1) + (longint'(smp) << tshd_pkg::FracBits);
          avg_new = AvgBits'(acc / n);
          avg_q[ch] = avg_new;
          level = avg_new[AvgBits-1:tshd_pkg::FracBits];
        end
        prod = (longint'(level) * 100 * longint'(gain_q)) >> AvgBits;
        r.pct = (prod > 100) ? tshd_pkg::PctMax : prod[tshd_pkg::LvlW-1:0];
      end
      t_lvl = (touch_lvl < 1) ? 1 : ((touch_lvl > 100) ? 100 : int'(touch_lvl));
      r_lvl = (rel_lvl < t_lvl - 1) ? int'(rel_lvl) : t_lvl - 1;
      chg = tshd_pkg::ChgNone;
      if (r.pct >= t_lvl) begin
        status = 1'b1;
        if (!actual_q[ch]) chg = tshd_pkg::ChgTouch;
      end else if (r.pct < r_lvl) begin
        status = 1'b0;
        if (actual_q[ch]) chg = tshd_pkg::ChgRelease;
      end else begin
        status = actual_q[ch];
      end
      actual_q[ch] = status;
      r.touched = status;
      if (toggle_on) begin
        if (chg == tshd_pkg::ChgRelease) begin
          chg = tshd_pkg::ChgNone;
        end else if (chg == tshd_pkg::ChgTouch) begin
          pseudo_q[ch] = !pseudo_q[ch];
          chg = pseudo_q[ch] ? tshd_pkg::ChgTouch : tshd_pkg::ChgRelease;
        end
        r.touched = pseudo_q[ch];
      end
      r.chg = chg;
      expected_q.push_back(r);
      n_items++;
    endfunction

    function void check_result(touch_result_t got);
      touch_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no item pending: ch %0d pct %0d touched %0d change %0d",
                 $time, got.ch, got.pct, got.touched, got.chg);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.ch !== exp_r.ch) begin
          $display("%0t: out_channel expected %0d actual %0d", $time, exp_r.ch, got.ch);
          errors++;
        end
        if (got.pct !== exp_r.pct) begin
          $display("%0t: percent expected %0d actual %0d", $time, exp_r.pct, got.pct);
          errors++;
        end
        if (got.touched !== exp_r.touched) begin
          $display("%0t: touched expected %0d actual %0d", $time, exp_r.touched, got.touched);
          errors++;
        end
        if (got.chg !== exp_r.chg) begin
          $display("%0t: change expected %0d actual %0d", $time, exp_r.chg, got.chg);
          errors++;
        end
      end
      n_checked++;
      if (got.chg == tshd_pkg::ChgTouch) n_touches++;
      if (got.chg == tshd_pkg::ChgRelease) n_releases++;
      if (got.pct == tshd_pkg::PctMax) n_full++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tshd_in_if #(.SampleBits(SampleBits)) in_bus ();
  tshd_out_if out_bus ();
  tshd_cfg_if cfg_bus ();

  touch_sensor_hysteresis_detector #(
    .CHANNELS   (Channels),
    .SAMPLE_BITS(SampleBits)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_bus),
    .out_if(out_bus),
    .cfg_if(cfg_bus)
  );

  touch_scoreboard sb;
  logic sink_calm;
  logic src_calm;
  logic hold_request;
  int   idle_cycles;
  int   cfg_writes;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_item(in_bus.channel, in_bus.sample);
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result({out_bus.out_channel, out_bus.percent, out_bus.touched,
                         out_bus.change});
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.write_reg(cfg_bus.index, cfg_bus.data);
        cfg_writes++;
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_bus.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if (stall_left != 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
        out_bus.ready = 1'b0;
        stall_left = pick_gap();
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  task automatic write_reg(logic [tshd_pkg::CfgIdxW-1:0] idx,
                           logic [tshd_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  function automatic logic [tshd_pkg::CfgDataW-1:0] pad(int unsigned v, int w, bit junk);
    logic [tshd_pkg::CfgDataW-1:0] d;
    d = junk ? tshd_pkg::CfgDataW'($urandom) : '0;
    d = (d >> w) << w;
    return d | tshd_pkg::CfgDataW'(v);
  endfunction

  task automatic set_config(int unsigned avg, int unsigned touch, int unsigned rel,
                            int unsigned gain, int unsigned tog, int unsigned mask,
                            bit junk);
    write_reg(tshd_pkg::RegAvgCount, pad(avg, tshd_pkg::CntW, junk));
    write_reg(tshd_pkg::RegTouchLvl, pad(touch, tshd_pkg::LvlW, junk));
    write_reg(tshd_pkg::RegRelLvl, pad(rel, tshd_pkg::LvlW, junk));
    write_reg(tshd_pkg::RegGain, pad(gain, tshd_pkg::GainW, junk));
    write_reg(tshd_pkg::RegToggle, pad(tog, 1, junk));
    write_reg(tshd_pkg::RegIgnore, pad(mask, tshd_pkg::MaskW, junk));
    if (junk) begin
      write_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi,
                tshd_pkg::CfgDataW'($urandom));
    end
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_item(logic [tshd_pkg::ChW-1:0] ch, logic [SampleBits-1:0] smp);
    int gap;
    gap = src_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   = 1'b1;
    in_bus.channel = ch;
    in_bus.sample  = smp;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int idx);
    int left;
    int run;
    int kind;
    int unsigned avg;
    int unsigned touch;
    int unsigned rel;
    int unsigned gain;
    logic [tshd_pkg::ChW-1:0] ch;
    logic [SampleBits-1:0] smp;
    case ($urandom_range(0, 4))
      0: avg = 0;
      1: avg = 1;
      2: avg = $urandom_range(2, 12);
      3: avg = 1023;
      default: avg = $urandom_range(0, 1023);
    endcase
    touch = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : 127)
                                        : $urandom_range(30, 100);
    rel = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : 127)
                                      : $urandom_range(0, (touch > 99) ? 99 : touch);
    case ($urandom_range(0, 4))
      0: gain = 0;
      1: gain = 4095;
      2: gain = 256;
      3: gain = $urandom_range(200, 600);
      default: gain = $urandom_range(0, 4095);
    endcase
    set_config(avg, touch, rel, gain, $urandom_range(0, 1),
               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 0, 1'b1);
    sink_calm = (idx % 3 == 2);
    src_calm  = (idx % 4 == 3);
    if (idx == 1) hold_request = 1'b1;
    left = PhaseItems;
    while (left > 0) begin
      ch   = tshd_pkg::ChW'($urandom_range(0, Channels - 1));
      run  = $urandom_range(1, 10);
      kind = $urandom_range(0, 4);
      for (int i = 0; i < run && left > 0; i++) begin
        case (kind)
          0: smp = SampleBits'($urandom_range(900, 1023));
          1: smp = SampleBits'($urandom_range(0, 80));
          2: begin
            smp = SampleBits'($urandom_range(0, 1023));
            ch  = tshd_pkg::ChW'($urandom_range(0, Channels - 1));
          end
          3: smp = ($urandom_range(0, 1) != 0) ? '1 : '0;
          default: smp = SampleBits'($urandom_range(550, 800));
        endcase
        send_item(ch, smp);
        left--;
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.errors = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    sink_calm = 1'b1;
    src_calm = 1'b1;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.channel = '0;
    in_bus.sample = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults, filter on
    send_item(3'd0, 10'd1023);
    drain();

    // bypass, hysteresis on channels 0 and 7
    set_config(0, 95, 65, 256, 0, 0, 1'b0);
    send_item(3'd0, 10'd1023);
    send_item(3'd0, 10'd800);
    send_item(3'd0, 10'd0);
    send_item(3'd1, 10'd512);
    send_item(3'd7, 10'd1023);
    send_item(3'd7, 10'd700);
    drain();

    // levels above range, full gain saturates, some channels ignored
    set_config(1, 127, 127, 4095, 0, 8'hA5, 1'b0);
    send_item(3'd0, 10'd1023);
    send_item(3'd1, 10'd1023);
    send_item(3'd1, 10'd0);
    send_item(3'd3, 10'd7);
    drain();

    // toggle mode, release suppressed, ignored top channel
    set_config(0, 12, 5, 256, 1, 8'h80, 1'b0);
    send_item(3'd0, 10'd1023);
    send_item(3'd0, 10'd0);
    send_item(3'd0, 10'd1023);
    send_item(3'd0, 10'd500);
    send_item(3'd7, 10'd1023);
    drain();

    // slowest filter, zero levels clamp
    set_config(1023, 0, 0, 4095, 0, 0, 1'b0);
    send_item(3'd2, 10'd1023);
    send_item(3'd2, 10'd1023);
    send_item(3'd2, 10'd0);
    drain();

    // every channel ignored
    set_config(2, 50, 20, 256, 0, 8'hFF, 1'b0);
    send_item(3'd5, 10'd1023);
    drain();

    for (int p = 0; p < RandPhases; p++) random_phase(p);

    repeat (40) @(posedge clk);
    $display("Checked %0d results for %0d items over %0d register writes.",
             sb.n_checked, sb.n_items, cfg_writes);
    $display("Saw %0d touches, %0d releases and %0d saturated readings.",
             sb.n_touches, sb.n_releases, sb.n_full);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tshd_pkg.sv
hw/rtl/tshd_if.sv
hw/rtl/touch_sensor_hysteresis_detector.sv
test/touch_sensor_hysteresis_detector_test.sv
